// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on i_clk, off while i_rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked on i_clk, also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- src/pltb_pkg.sv -----
// ----------------------------------------------------------------------------
// pltb_pkg
// Types and constants for the password-locked tilt blinker.
// ----------------------------------------------------------------------------
package pltb_pkg;

    // lock state
    typedef enum logic [1:0] {
        PH_WAIT,
        PH_ENTRY,
        PH_OPEN
    } t_phase;

    // item kinds
    localparam logic [1:0] CMD_KEY    = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // register map, index = paddr[4:2]
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_PASSWORD  = 3'd0;
    localparam logic [2:0] REG_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_SLOW      = 3'd2;
    localparam logic [2:0] REG_FAST      = 3'd3;
    localparam logic [2:0] REG_START     = 3'd4;
    localparam logic [2:0] REG_INTERVAL  = 3'd5;

    // register reset values
    localparam logic [31:0] RST_PASSWORD  = 32'h3433_3231;  // "1234"
    localparam logic [14:0] RST_THRESHOLD = 15'd1000;
    localparam logic [15:0] RST_SLOW      = 16'd250;
    localparam logic [15:0] RST_FAST      = 16'd75;
    localparam logic [15:0] RST_START     = 16'd500;
    localparam logic [15:0] RST_INTERVAL  = 16'd200;

    localparam logic [7:0] KEY_CR = 8'h0D;
    localparam logic [7:0] KEY_LF = 8'h0A;

    localparam logic [14:0] MAG_MAX = 15'h7FFF;

endpackage

// ----- src/password_locked_tilt_blinker.sv -----
// Throughput: one item per cycle if the output is not stalled; the path is one input
// register, the state update logic (abs/saturate, 3/4 average add, timer compares)
// and one result register.
// Reset (synchronous, active low) clears the pipeline, locks the block, loads
// the register defaults and sets the blink period to the start period default.
// ----------------------------------------------------------------------------
// password_locked_tilt_blinker
// Password gate in front of a tilt-driven LED blinker with an APB register port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module password_locked_tilt_blinker #(
    parameter int KEY_SLOTS  = 4,
    parameter int TIMER_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // item channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_cmd,
    input  logic [7:0]                  i_key_byte,
    input  logic signed [15:0]          i_accel_sample,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_led_on,
    output logic                        o_is_unlocked,
    output logic                        o_bad_password,
    output logic                        o_filtered_valid,
    output logic [14:0]                 o_filtered_value,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pltb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pltb_pkg::*;

    localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int CNT_W = $clog2(KEY_SLOTS + 1);
    localparam int PW_W  = KEY_SLOTS * 8;
    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    // ---------------- registers ----------------
    logic [31:0]           r_password;
    logic [14:0]           r_threshold;
    logic [15:0]           r_slow;
    logic [15:0]           r_fast;
    logic [15:0]           r_start;
    logic [15:0]           r_interval;

    logic                  r_in_valid;
    logic [1:0]            r_cmd;
    logic [7:0]            r_key;
    logic signed [15:0]    r_sample;

    t_phase                r_phase,    n_phase;
    logic [7:0]            r_key_store [KEY_SLOTS];
    logic [CNT_W-1:0]      r_key_count, n_key_count;
    logic [14:0]           r_avg,      n_avg;
    logic                  r_primed,   n_primed;
    logic                  r_level,    n_level;
    logic [15:0]           r_period,   n_period;
    logic [TIMER_BITS-1:0] r_btimer,   n_btimer;
    logic [TIMER_BITS-1:0] r_utimer,   n_utimer;
    logic                  r_led,      n_led;

    logic                  r_out_valid;
    logic                  r_o_led;
    logic                  r_o_open;
    logic                  r_o_bad;
    logic                  r_o_fvalid;
    logic [14:0]           r_o_fval;

    // ---------------- handshake ----------------
    logic w_out_adv;
    logic w_step;
    logic w_cfg_we;
    logic [2:0] w_reg_idx;

    assign w_out_adv = !r_out_valid || !i_stall;
    assign w_step    = r_in_valid && w_out_adv;
    assign o_stall   = r_in_valid && !w_out_adv;
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:2];
    assign w_cfg_we  = psel && penable && pwrite && pready;

    // ---------------- datapath ----------------
    logic [PW_W-1:0]       w_pw;
    logic                  w_match;
    logic [15:0]           w_raw;
    logic [16:0]           w_abs;
    logic [14:0]           w_mag;
    logic [14:0]           w_mag_m;
    logic [17:0]           w_sum;
    logic [14:0]           w_new_avg;
    logic [TIMER_BITS-1:0] w_bt_inc;
    logic [TIMER_BITS-1:0] w_ut_inc;
    logic                  w_bad;
    logic                  w_fvalid;
    logic [14:0]           w_fval;
    logic                  w_key_we;
    logic [IDX_W-1:0]      w_key_idx;

    // slots past the fourth compare against zero
    assign w_pw = PW_W'(r_password);

    always_comb begin
        w_match = (r_key_count == CNT_W'(KEY_SLOTS));
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (r_key_store[i] != w_pw[8*i +: 8]) begin
                w_match = 1'b0;
            end
        end
    end

    assign w_raw     = $unsigned(r_sample);
    assign w_abs     = w_raw[15] ? (17'h10000 - {1'b0, w_raw}) : {1'b0, w_raw};
    assign w_mag     = (w_abs > {2'b00, MAG_MAX}) ? MAG_MAX : w_abs[14:0];
    assign w_mag_m   = {w_mag[14:2], 2'b00};
    assign w_sum     = 18'({r_avg, 1'b0}) + 18'(r_avg) + 18'(w_mag_m);
    assign w_new_avg = r_primed ? w_sum[16:2] : w_mag_m;

    assign w_bt_inc = (r_btimer == '1) ? r_btimer : r_btimer + TIMER_BITS'(1);
    assign w_ut_inc = (r_utimer == '1) ? r_utimer : r_utimer + TIMER_BITS'(1);

    always_comb begin
        n_phase     = r_phase;
        n_key_count = r_key_count;
        n_avg       = r_avg;
        n_primed    = r_primed;
        n_level     = r_level;
        n_period    = r_period;
        n_btimer    = r_btimer;
        n_utimer    = r_utimer;
        n_led       = r_led;
        w_bad       = 1'b0;
        w_fvalid    = 1'b0;
        w_fval      = '0;
        w_key_we    = 1'b0;
        w_key_idx   = '0;
        unique case (r_cmd)
            CMD_KEY: begin
                unique case (r_phase)
                    PH_WAIT: begin
                        // any byte, CR and LF too, opens an entry
                        w_key_we    = 1'b1;
                        n_key_count = CNT_W'(1);
                        n_phase     = PH_ENTRY;
                    end
                    PH_ENTRY: begin
                        if (r_key == KEY_CR || r_key == KEY_LF) begin
                            if (w_match) begin
                                n_phase = PH_OPEN;
                            end else begin
                                n_phase = PH_WAIT;
                                w_bad   = 1'b1;
                            end
                            n_key_count = '0;
                        end else if (r_key_count < CNT_W'(KEY_SLOTS)) begin
                            w_key_we    = 1'b1;
                            w_key_idx   = r_key_count[IDX_W-1:0];
                            n_key_count = r_key_count + CNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_SAMPLE: begin
                if (r_phase == PH_OPEN) begin
                    n_avg    = w_new_avg;
                    n_primed = 1'b1;
                    w_fvalid = 1'b1;
                    w_fval   = w_new_avg;
                    if (CMP_W'(r_utimer) >= CMP_W'(r_interval)) begin
                        // period follows the level before this update
                        if (!r_level) begin
                            n_period = r_slow;
                            if (w_new_avg > r_threshold) begin
                                n_level = 1'b1;
                            end
                        end else begin
                            n_period = r_fast;
                            if (w_new_avg < r_threshold) begin
                                n_level = 1'b0;
                            end
                        end
                        n_utimer = '0;
                    end
                end
            end
            CMD_TICK: begin
                n_utimer = w_ut_inc;
                if (r_phase != PH_OPEN) begin
                    n_led    = 1'b0;
                    n_btimer = '0;
                end else if (CMP_W'(w_bt_inc) >= CMP_W'(r_period)) begin
                    n_btimer = '0;
                    n_led    = !r_led;
                end else begin
                    n_btimer = w_bt_inc;
                end
            end
            default: begin
            end
        endcase
        if (!r_in_valid) begin
            w_key_we = 1'b0;
        end
    end

    // ---------------- input stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_cmd    <= i_cmd;
            r_key    <= i_key_byte;
            r_sample <= i_accel_sample;
        end
    end

    // ---------------- state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_key_count <= '0;
            r_avg       <= '0;
            r_primed    <= 1'b0;
            r_level     <= 1'b0;
            r_period    <= RST_START;
            r_btimer    <= '0;
            r_utimer    <= '0;
            r_led       <= 1'b0;
        end else begin
            if (w_step) begin
                r_phase     <= n_phase;
                r_key_count <= n_key_count;
                r_avg       <= n_avg;
                r_primed    <= n_primed;
                r_level     <= n_level;
                r_period    <= n_period;
                r_btimer    <= n_btimer;
                r_utimer    <= n_utimer;
                r_led       <= n_led;
            end
            if (w_cfg_we && w_reg_idx == REG_START) begin
                r_period <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_key_we) begin
            r_key_store[w_key_idx] <= r_key;
        end
    end

    // ---------------- result stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_o_led    <= n_led;
            r_o_open   <= (n_phase == PH_OPEN);
            r_o_bad    <= w_bad;
            r_o_fvalid <= w_fvalid;
            r_o_fval   <= w_fval;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_led_on         = r_o_led;
    assign o_is_unlocked    = r_o_open;
    assign o_bad_password   = r_o_bad;
    assign o_filtered_valid = r_o_fvalid;
    assign o_filtered_value = r_o_fval;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_password  <= RST_PASSWORD;
            r_threshold <= RST_THRESHOLD;
            r_slow      <= RST_SLOW;
            r_fast      <= RST_FAST;
            r_start     <= RST_START;
            r_interval  <= RST_INTERVAL;
        end else if (w_cfg_we) begin
            unique case (w_reg_idx)
                REG_PASSWORD:  r_password  <= pwdata;
                REG_THRESHOLD: r_threshold <= pwdata[14:0];
                REG_SLOW:      r_slow      <= pwdata[15:0];
                REG_FAST:      r_fast      <= pwdata[15:0];
                REG_START:     r_start     <= pwdata[15:0];
                REG_INTERVAL:  r_interval  <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_PASSWORD:  prdata = r_password;
            REG_THRESHOLD: prdata = 32'(r_threshold);
            REG_SLOW:      prdata = 32'(r_slow);
            REG_FAST:      prdata = 32'(r_fast);
            REG_START:     prdata = 32'(r_start);
            REG_INTERVAL:  prdata = 32'(r_interval);
            default:       prdata = '0;
        endcase
    end

    // ---------------- assertions ----------------
    `ASSERT_CLK(a_open_sticky, r_phase == PH_OPEN |=> r_phase == PH_OPEN, "unlock was lost")
    `ASSERT_CLK(a_bad_locked, o_valid && o_bad_password |-> !o_is_unlocked, "bad beat while open")
    `ASSERT_CLK(a_filt_open, o_valid && o_filtered_valid |-> o_is_unlocked, "filter ran while locked")
    `ASSERT_CLK(a_led_locked, r_phase != PH_OPEN |-> !r_led, "LED on while locked")

endmodule
